>>> rtl/assert_macros.svh
// Assertion macros for the controller's RTL files, used by the call queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication that must hold at every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/ecc_pkg.sv
// Constants, codes and shared types of the elevator call controller.
`default_nettype none

package ecc_pkg;

    localparam int FLOORS      = 16;
    localparam int QUEUE_DEPTH = 8;

    localparam int FLOOR_W = 5;
    localparam int REQ_W   = 3;
    localparam int RES_W   = 2;
    localparam int STAT_W  = 3;
    localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD   = 3'd0,
        REQ_START = 3'd1,
        REQ_TICK  = 3'd2,
        REQ_ARRIVE = 3'd3,
        REQ_FREE  = 3'd4
    } req_code_t;

    typedef enum logic [STAT_W-1:0] {
        ST_FREE    = 3'd0,
        ST_ADDING  = 3'd1,
        ST_DEPART  = 3'd2,
        ST_START   = 3'd3,
        ST_MOVING  = 3'd4,
        ST_ARRIVAL = 3'd5
    } ctrl_status_t;

    typedef enum logic [RES_W-1:0] {
        RES_NONE     = 2'd0,
        RES_DEPARTED = 2'd1,
        RES_REACHED  = 2'd2
    } event_res_t;

    // Commands from the sequencer to the call queue.
    typedef struct packed {
        logic               push;
        logic               depart;
        logic               use_max;
        logic [FLOOR_W-1:0] floor;
    } q_cmd_t;

    // Status from the call queue back to the sequencer.
    typedef struct packed {
        logic               full;
        logic               empty;
        logic               done;
        logic [FLOOR_W-1:0] goal;
    } q_sts_t;

endpackage

`default_nettype wire

>>> rtl/ecc_req_if.sv
// Event channel: valid/ready handshake carrying one controller event.
`default_nettype none

interface ecc_req_if;
    import ecc_pkg::*;

    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [FLOOR_W-1:0] call_floor;

    modport source (output valid, output req_type, output call_floor, input ready);
    modport sink   (input valid, input req_type, input call_floor, output ready);
endinterface

`default_nettype wire

>>> rtl/ecc_res_if.sv
// Result channel: valid/ready handshake carrying one controller result.
`default_nettype none

interface ecc_res_if;
    import ecc_pkg::*;

    logic               valid;
    logic               ready;
    logic [RES_W-1:0]   event_res;
    logic [FLOOR_W-1:0] event_floor;
    logic [STAT_W-1:0]  status_now;
    logic [FLOOR_W-1:0] floor_now;
    logic               call_dropped;

    modport source (output valid, output event_res, output event_floor, output status_now,
                    output floor_now, output call_dropped, input ready);
    modport sink   (input valid, input event_res, input event_floor, input status_now,
                    input floor_now, input call_dropped, output ready);
endinterface

`default_nettype wire

>>> rtl/elevator_call_controller.sv
// Top level of the elevator call controller: event sequencer, cabin state, result register and call queue.
`default_nettype none

// The controller takes one event per transfer on req and returns exactly one result per
// event on res. Floor ticks, start, arrival, unknown codes and calls that cause no departure
// go straight from the accepting edge to the result state, and their result is handed to
// the output register as soon as that register is free; the next event can be taken from
// then on. A departure (a call made while free, or a free event with calls pending) is
// settled by the call queue, whose single memory read port and single comparator visit one
// entry per cycle: the scan visits every queued call when the largest floor is sought and
// only the first entry when the oldest call is taken, and the compaction then moves every
// entry above the chosen one down one place. The block accepts no event while one is being
// worked on. A finished result waits in the output register, and the next event may already
// be taken and processed meanwhile; it is then held until the previous result has been
// transferred. The call queue needs no clearing after reset, since only entries below its
// fill count are ever used.

module elevator_call_controller (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ecc_req_if.sink    req,
    ecc_res_if.source  res
);
    import ecc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEP_REQ,
        S_DEP_WAIT,
        S_DONE
    } seq_state_t;

    seq_state_t         state_reg;
    ctrl_status_t       status_reg;
    logic [FLOOR_W-1:0] cabin_reg;
    logic [FLOOR_W-1:0] goal_reg;
    logic               up_reg;
    logic               timer_reg;

    // Result of the event in progress.
    event_res_t         res_reg;
    logic [FLOOR_W-1:0] evfl_reg;
    logic               drop_reg;

    // Output register.
    logic               out_valid_reg;
    event_res_t         out_res_reg;
    logic [FLOOR_W-1:0] out_evfl_reg;
    ctrl_status_t       out_status_reg;
    logic [FLOOR_W-1:0] out_floor_reg;
    logic               out_drop_reg;

    q_cmd_t             q_cmd;
    q_sts_t             q_sts;

    logic               accept;
    logic               out_free;
    logic [FLOOR_W-1:0] fl_sat;

    // Values that an accepted event produces before any departure.
    ctrl_status_t       status_next;
    logic [FLOOR_W-1:0] cabin_next;
    logic               up_next;
    logic               timer_next;
    event_res_t         res_next;
    logic [FLOOR_W-1:0] evfl_next;
    logic               drop_next;
    logic               dep_next;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || res.ready;

    always_comb
    begin
        if (req.call_floor == '0)
        begin
            fl_sat = FLOOR_W'(1);
        end
        else if (req.call_floor > FLOOR_W'(FLOORS))
        begin
            fl_sat = FLOOR_W'(FLOORS);
        end
        else
        begin
            fl_sat = req.call_floor;
        end
    end

    always_comb
    begin
        status_next = status_reg;
        cabin_next  = cabin_reg;
        up_next     = up_reg;
        timer_next  = timer_reg;
        res_next    = RES_NONE;
        evfl_next   = '0;
        drop_next   = 1'b0;
        dep_next    = 1'b0;
        unique case (req.req_type)
            REQ_ADD:
            begin
                status_next = ST_ADDING;
                drop_next   = q_sts.full;
                // After the call is queued the queue is never empty, so a call made
                // while free always departs.
                dep_next    = (status_reg == ST_FREE);
            end
            REQ_START:
            begin
                if ((status_reg == ST_DEPART) || (status_reg == ST_ADDING))
                begin
                    status_next = ST_START;
                    up_next     = !(cabin_reg > goal_reg);
                    timer_next  = 1'b1;
                end
            end
            REQ_TICK:
            begin
                if (timer_reg && (status_reg != ST_FREE) && (status_reg != ST_ARRIVAL))
                begin
                    status_next = ST_MOVING;
                    if (cabin_reg == goal_reg)
                    begin
                        timer_next = 1'b0;
                        res_next   = RES_REACHED;
                        evfl_next  = goal_reg;
                    end
                    else if (up_reg)
                    begin
                        if (cabin_reg < FLOOR_W'(FLOORS))
                        begin
                            cabin_next = cabin_reg + FLOOR_W'(1);
                        end
                    end
                    else if (cabin_reg > FLOOR_W'(1))
                    begin
                        cabin_next = cabin_reg - FLOOR_W'(1);
                    end
                end
            end
            REQ_ARRIVE:
            begin
                if ((status_reg == ST_ADDING) || (status_reg == ST_MOVING)
                    || (status_reg == ST_DEPART))
                begin
                    status_next = ST_ARRIVAL;
                end
            end
            REQ_FREE:
            begin
                if ((status_reg == ST_ADDING) || (status_reg == ST_ARRIVAL))
                begin
                    status_next = ST_FREE;
                    dep_next    = !q_sts.empty;
                end
            end
            default:
            begin
                // Unknown event codes change nothing.
            end
        endcase
        if (dep_next)
        begin
            status_next = ST_DEPART;
        end
    end

    // The queue takes the call at the accepting edge and starts a departure from S_DEP_REQ.
    assign q_cmd.push    = accept && (req.req_type == REQ_ADD);
    assign q_cmd.floor   = fl_sat;
    assign q_cmd.depart  = (state_reg == S_DEP_REQ);
    assign q_cmd.use_max = (goal_reg != '0);

    ecc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (q_cmd),
        .sts   (q_sts)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            status_reg     <= ST_FREE;
            cabin_reg      <= FLOOR_W'(1);
            goal_reg       <= '0;
            up_reg         <= 1'b1;
            timer_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            res_reg        <= RES_NONE;
            evfl_reg       <= '0;
            drop_reg       <= 1'b0;
            out_res_reg    <= RES_NONE;
            out_evfl_reg   <= '0;
            out_status_reg <= ST_FREE;
            out_floor_reg  <= FLOOR_W'(1);
            out_drop_reg   <= 1'b0;
        end
        else
        begin
            // The output register empties on its transfer unless a new result replaces it.
            if (res.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        status_reg <= status_next;
                        cabin_reg  <= cabin_next;
                        up_reg     <= up_next;
                        timer_reg  <= timer_next;
                        res_reg    <= res_next;
                        evfl_reg   <= evfl_next;
                        drop_reg   <= drop_next;
                        state_reg  <= dep_next ? S_DEP_REQ : S_DONE;
                    end
                end
                S_DEP_REQ:
                begin
                    state_reg <= S_DEP_WAIT;
                end
                S_DEP_WAIT:
                begin
                    if (q_sts.done)
                    begin
                        goal_reg  <= q_sts.goal;
                        evfl_reg  <= q_sts.goal;
                        res_reg   <= (cabin_reg == q_sts.goal) ? RES_REACHED : RES_DEPARTED;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // Hand the result over once the output register is free.
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_res_reg    <= res_reg;
                        out_evfl_reg   <= evfl_reg;
                        out_status_reg <= status_reg;
                        out_floor_reg  <= cabin_reg;
                        out_drop_reg   <= drop_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.event_res    = out_res_reg;
    assign res.event_floor  = out_evfl_reg;
    assign res.status_now   = out_status_reg;
    assign res.floor_now    = out_floor_reg;
    assign res.call_dropped = out_drop_reg;

endmodule

`default_nettype wire

>>> rtl/ecc_queue.sv
// Call queue: memory of pending calls, scanned by a single compare unit and then compacted.
`default_nettype none
`include "assert_macros.svh"

module ecc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ecc_pkg::q_cmd_t cmd,
    output ecc_pkg::q_sts_t     sts
);
    import ecc_pkg::*;

    typedef enum logic [1:0] {
        Q_IDLE,
        Q_SCAN,
        Q_SHIFT,
        Q_FIN
    } q_state_t;

    q_state_t           state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   last_reg;
    logic               issue_reg;
    logic               cmp_valid_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic [FLOOR_W-1:0] best_reg;
    logic [IDX_W-1:0]   pick_reg;
    logic               wr_valid_reg;
    logic [IDX_W-1:0]   wr_addr_reg;

    logic [FLOOR_W-1:0] mem [QUEUE_DEPTH];
    logic [FLOOR_W-1:0] rd_data_reg;

    logic               full;
    logic               push_ok;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [FLOOR_W-1:0] wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [CNT_W-1:0]   cnt_m1;
    logic               take;
    logic [FLOOR_W-1:0] best_next;
    logic [IDX_W-1:0]   pick_next;
    logic               scan_end;
    logic               shift_go;

    assign full     = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign push_ok  = (state_reg == Q_IDLE) && cmd.push && !full;
    assign cnt_m1   = cnt_reg - CNT_W'(1);

    // One compare per cycle: keep the first occurrence of the largest floor.
    assign take      = cmp_valid_reg && ((cmp_idx_reg == '0) || (rd_data_reg > best_reg));
    assign best_next = take ? rd_data_reg : best_reg;
    assign pick_next = take ? cmp_idx_reg : pick_reg;
    assign scan_end  = (state_reg == Q_SCAN) && cmp_valid_reg && (cmp_idx_reg == last_reg);
    assign shift_go  = ((CNT_W'(idx_reg) + CNT_W'(1)) < cnt_reg);

    assign rd_addr = (state_reg == Q_SCAN) ? idx_reg : (idx_reg + IDX_W'(1));
    assign wr_en   = push_ok || wr_valid_reg;
    assign wr_addr = push_ok ? cnt_reg[IDX_W-1:0] : wr_addr_reg;
    assign wr_data = push_ok ? cmd.floor : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= Q_IDLE;
            cnt_reg       <= '0;
            issue_reg     <= 1'b0;
            cmp_valid_reg <= 1'b0;
            wr_valid_reg  <= 1'b0;
            idx_reg       <= '0;
            last_reg      <= '0;
            cmp_idx_reg   <= '0;
            best_reg      <= '0;
            pick_reg      <= '0;
            wr_addr_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                Q_IDLE:
                begin
                    wr_valid_reg <= 1'b0;
                    if (push_ok)
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    if (cmd.depart)
                    begin
                        idx_reg       <= '0;
                        last_reg      <= cmd.use_max ? cnt_m1[IDX_W-1:0] : '0;
                        issue_reg     <= 1'b1;
                        cmp_valid_reg <= 1'b0;
                        state_reg     <= Q_SCAN;
                    end
                end
                Q_SCAN:
                begin
                    best_reg    <= best_next;
                    pick_reg    <= pick_next;
                    cmp_idx_reg <= idx_reg;
                    if (scan_end)
                    begin
                        idx_reg       <= pick_next;
                        cmp_valid_reg <= 1'b0;
                        state_reg     <= Q_SHIFT;
                    end
                    else
                    begin
                        cmp_valid_reg <= issue_reg;
                        if (issue_reg)
                        begin
                            if (idx_reg == last_reg)
                            begin
                                issue_reg <= 1'b0;
                            end
                            else
                            begin
                                idx_reg <= idx_reg + IDX_W'(1);
                            end
                        end
                    end
                end
                Q_SHIFT:
                begin
                    // Read the entry above, and write it one place down in the following cycle.
                    if (shift_go)
                    begin
                        wr_valid_reg <= 1'b1;
                        wr_addr_reg  <= idx_reg;
                        idx_reg      <= idx_reg + IDX_W'(1);
                    end
                    else
                    begin
                        wr_valid_reg <= 1'b0;
                        state_reg    <= Q_FIN;
                    end
                end
                Q_FIN:
                begin
                    cnt_reg   <= cnt_m1;
                    state_reg <= Q_IDLE;
                end
                default:
                begin
                    state_reg <= Q_IDLE;
                end
            endcase
        end
    end

    assign sts.full  = full;
    assign sts.empty = (cnt_reg == '0);
    assign sts.done  = (state_reg == Q_FIN);
    assign sts.goal  = best_reg;

    `ASSERT_CLK(a_cnt_bound, clk, rst_n, cnt_reg <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
    `ASSERT_IMPL(a_dep_nonempty, clk, rst_n, cmd.depart, cnt_reg != '0, "departure from empty queue")
    `ASSERT_IMPL(a_fin_after_shift, clk, rst_n, state_reg == Q_FIN, $past(state_reg) == Q_SHIFT, "finish not preceded by compaction")

endmodule

`default_nettype wire
